// File: rtl/core/mgr_pkg.sv
// Package for the min gap and range tracker: probe, result and state types,
// status codes and fixed widths. No dependencies.
package mgr_pkg;

   localparam int WORD_W = 32;
   localparam int CAP_W = 7;
   localparam int STAT_W = 2;

   localparam logic [STAT_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FEW = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
   localparam int MIN_FOR_SPANS = 2;

   // probe token walking down the cell chain
   typedef struct packed {
      logic              valid;
      logic              store;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] gap;
   } probe_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [WORD_W-1:0] shortest;
      logic [WORD_W-1:0] longest;
      logic [CAP_W-1:0]  count;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

endpackage

// File: rtl/core/mgr_cell.sv
// One cell of the tracker chain: holds one stored value and folds its gap to
// the passing probe into the running minimum. Depends on mgr_pkg.
module mgr_cell
   import mgr_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CW = 7
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [CW-1:0]   count_i,
   input  probe_type       probe_i,
   output probe_type       probe_o
);

   logic [WORD_W-1:0] held_ff, held_in;
   probe_type         probe_ff, probe_in;
   logic              occupied;
   logic              is_slot;
   logic              v_less;
   logic [WORD_W-1:0] diff;

   assign occupied = (CW'(INDEX) < count_i);
   assign is_slot  = (CW'(INDEX) == count_i);
   assign v_less   = ($signed(probe_i.value) < $signed(held_ff));
   assign diff     = v_less ? (held_ff - probe_i.value) : (probe_i.value - held_ff);

   always_comb begin
      probe_in = probe_i;
      held_in  = held_ff;
      if (probe_i.valid && probe_i.store) begin
         if (occupied && (diff < probe_i.gap)) begin
            probe_in.gap = diff;
         end
         // first free slot takes the new value
         if (is_slot) begin
            held_in = probe_i.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign probe_o = probe_ff;

endmodule

// File: rtl/core/min_gap_and_range_tracker_unit.sv
// Top level of the min gap and range tracker: control, span registers and
// the chain of mgr_cell instances. Depends on mgr_pkg and mgr_cell.
//
// Usage:
// - req_ channel: one signed 32-bit value per transfer (valid/ready).
// - rsp_ channel: one result per input transfer: status, shortest gap,
//   spread (max - min) and number of values held.
// - csr_: single write-only capacity register, taken at any edge with
//   csr_write_enable high; write it only while the block is idle.
// Timing: a transfer launches a probe down a chain of STORE_DEPTH cells, one
// cell per cycle. The result is registered when the probe leaves the chain;
// a new request is taken only back in idle, once the previous result has
// reached the output register.
// The finished result sits in an output register. If it is still waiting
// when the next probe leaves the chain, the new result waits in a hold
// register and req_ready stays low until rsp_ready returns.
// Reset: store empty, best gap all ones, capacity 64. No clearing pass.
module min_gap_and_range_tracker_unit
   import mgr_pkg::*;
#(
   parameter int STORE_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [WORD_W-1:0]   req_new_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [WORD_W-1:0]   rsp_shortest_span,
   output logic [WORD_W-1:0]   rsp_longest_span,
   output logic [CAP_W-1:0]    rsp_stored_count,
   input  logic                csr_write_enable,
   input  logic [CAP_W-1:0]    csr_write_data
);

   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int LW = (CW > CAP_W) ? CW : CAP_W;

   state_type state_ff, state_in;

   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [WORD_W-1:0] smallest_ff, smallest_in;
   logic [WORD_W-1:0] largest_ff, largest_in;
   logic [WORD_W-1:0] best_gap_ff, best_gap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        out_ff, out_in;
   result_type        hold_ff, hold_in;

   probe_type link [STORE_DEPTH+1];
   probe_type tail;

   logic              accept;
   logic              reject;
   logic              out_free;
   logic              load_tail_out;
   logic              load_tail_hold;
   logic              load_hold_out;
   logic [CW-1:0]     new_count;
   logic [WORD_W-1:0] new_gap;
   logic [WORD_W-1:0] new_min;
   logic [WORD_W-1:0] new_max;
   logic              spans_ok;
   result_type        tail_result;

   // full when held count reaches capacity or physical depth
   assign reject = (LW'(count_ff) >= LW'(capacity_ff)) || (count_ff >= CW'(STORE_DEPTH));
   assign accept = req_valid && req_ready;

   always_comb begin
      link[0].valid = accept;
      link[0].store = !reject;
      link[0].value = req_new_value;
      link[0].gap   = best_gap_ff;
   end

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      mgr_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .count_i (count_ff),
         .probe_i (link[i]),
         .probe_o (link[i+1])
      );
   end

   assign tail = link[STORE_DEPTH];

   // state update from the probe leaving the chain
   always_comb begin
      new_count = count_ff;
      new_gap   = best_gap_ff;
      new_min   = smallest_ff;
      new_max   = largest_ff;
      if (tail.store) begin
         new_count = count_ff + CW'(1);
         new_gap   = tail.gap;
         if (count_ff == '0) begin
            new_min = tail.value;
            new_max = tail.value;
         end else begin
            if ($signed(tail.value) < $signed(smallest_ff)) begin
               new_min = tail.value;
            end
            if ($signed(largest_ff) < $signed(tail.value)) begin
               new_max = tail.value;
            end
         end
      end
      spans_ok = (new_count >= CW'(MIN_FOR_SPANS));
      if (!tail.store) begin
         tail_result.status = STATUS_FULL;
      end else if (!spans_ok) begin
         tail_result.status = STATUS_FEW;
      end else begin
         tail_result.status = STATUS_OK;
      end
      tail_result.shortest = spans_ok ? new_gap : '0;
      tail_result.longest  = spans_ok ? (new_max - new_min) : '0;
      tail_result.count    = CAP_W'(new_count);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (tail.valid) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      req_ready      = 1'b0;
      load_tail_out  = 1'b0;
      load_tail_hold = 1'b0;
      load_hold_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_RUN: begin
            load_tail_out  = tail.valid && out_free;
            load_tail_hold = tail.valid && !out_free;
         end
         ST_HOLD: begin
            load_hold_out = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      capacity_in  = csr_write_enable ? csr_write_data : capacity_ff;
      count_in     = count_ff;
      best_gap_in  = best_gap_ff;
      smallest_in  = smallest_ff;
      largest_in   = largest_ff;
      if (tail.valid) begin
         count_in    = new_count;
         best_gap_in = new_gap;
         smallest_in = new_min;
         largest_in  = new_max;
      end
      out_in  = out_ff;
      hold_in = hold_ff;
      if (load_tail_out) begin
         out_in = tail_result;
      end else if (load_hold_out) begin
         out_in = hold_ff;
      end
      if (load_tail_hold) begin
         hold_in = tail_result;
      end
      if (load_tail_out || load_hold_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         smallest_ff  <= '0;
         largest_ff   <= '0;
         best_gap_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         smallest_ff  <= smallest_in;
         largest_ff   <= largest_in;
         best_gap_ff  <= best_gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_shortest_span = out_ff.shortest;
   assign rsp_longest_span  = out_ff.longest;
   assign rsp_stored_count  = out_ff.count;

endmodule

// File: test/min_gap_checker.sv
`timescale 1ns / 100ps
// Checker for the min gap and range tracker: mirrors store, spans and capacity,
// compares every result transfer in order. Depends on mgr_pkg.
module min_gap_checker
   import mgr_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [WORD_W-1:0] req_new_value,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [STAT_W-1:0] rsp_status,
   input  logic [WORD_W-1:0] rsp_shortest_span,
   input  logic [WORD_W-1:0] rsp_longest_span,
   input  logic [CAP_W-1:0]  rsp_stored_count,
   input  logic              csr_write_enable,
   input  logic [CAP_W-1:0]  csr_write_data,
   output int                failures,
   output int                outstanding
);

   logic [WORD_W-1:0] kept_values [DEPTH];
   int                kept_count;
   logic [WORD_W-1:0] lowest_kept;
   logic [WORD_W-1:0] highest_kept;
   logic [WORD_W-1:0] closest_gap;
   logic [CAP_W-1:0]  capacity_setting;
   result_type        expected_spans [$];
   int                items_taken = 0;
   int                results_seen = 0;

   assign outstanding = items_taken - results_seen;

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("%0t: %s mismatch, got %0h want %0h", $time, what, got, want);
      failures++;
   endtask

   // One value into the mirrored tracker; gives the result it should cause.
   task automatic absorb_value(input logic [WORD_W-1:0] v, output result_type r);
      int                limit;
      logic [WORD_W-1:0] gap;
      limit = (capacity_setting > DEPTH) ? DEPTH : capacity_setting;
      if (kept_count >= limit) begin
         r.status = STATUS_FULL;
      end else begin
         for (int i = 0; i < kept_count; i++) begin
            gap = ($signed(v) < $signed(kept_values[i])) ? kept_values[i] - v
                                                         : v - kept_values[i];
            if (gap < closest_gap) closest_gap = gap;
         end
         if (kept_count == 0) begin
            lowest_kept = v;
            highest_kept = v;
         end else begin
            if ($signed(v) < $signed(lowest_kept)) lowest_kept = v;
            if ($signed(highest_kept) < $signed(v)) highest_kept = v;
         end
         kept_values[kept_count] = v;
         kept_count++;
         r.status = (kept_count < MIN_FOR_SPANS) ? STATUS_FEW : STATUS_OK;
      end
      r.shortest = (kept_count >= MIN_FOR_SPANS) ? closest_gap : '0;
      r.longest = (kept_count >= MIN_FOR_SPANS) ? highest_kept - lowest_kept : '0;
      r.count = kept_count[CAP_W-1:0];
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         failures = 0;
         kept_count = 0;
         lowest_kept = '0;
         highest_kept = '0;
         closest_gap = '1;
         capacity_setting = CAP_RESET;
         expected_spans.delete();
         items_taken <= 0;
         results_seen <= 0;
      end else begin
         if (csr_write_enable) capacity_setting = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_spans.size() == 0) begin
               report_mismatch("unexpected result, shortest span", rsp_shortest_span, '0);
            end else begin
               want = expected_spans.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_shortest_span !== want.shortest)
                  report_mismatch("shortest span", rsp_shortest_span, want.shortest);
               if (rsp_longest_span !== want.longest)
                  report_mismatch("longest span", rsp_longest_span, want.longest);
               if (rsp_stored_count !== want.count)
                  report_mismatch("stored count", rsp_stored_count, want.count);
            end
         end
         if (req_valid && req_ready) begin
            absorb_value(req_new_value, want);
            expected_spans = {expected_spans, want};
            items_taken <= items_taken + 1;
         end
      end
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Top of the tracker testbench: clock, reset, stimulus and verdict.
// Depends on mgr_pkg, min_gap_and_range_tracker_unit and min_gap_checker.
module testbench
   import mgr_pkg::*;
();

   localparam int STORE_DEPTH = 64;
   localparam logic [WORD_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [WORD_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;
   localparam logic [CAP_W-1:0] CAP_NONE = 7'd0;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [WORD_W-1:0] req_new_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [STAT_W-1:0] rsp_status;
   logic [WORD_W-1:0] rsp_shortest_span;
   logic [WORD_W-1:0] rsp_longest_span;
   logic [CAP_W-1:0]  rsp_stored_count;
   logic              csr_write_enable;
   logic [CAP_W-1:0]  csr_write_data;
   int                failures;
   int                outstanding;
   bit                quiet = 1'b0;     // set for the closing stretch: no idling
   logic [WORD_W-1:0] sent_values [$];  // pool for duplicate picks

   min_gap_and_range_tracker_unit #(
      .STORE_DEPTH(STORE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_new_value(req_new_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_shortest_span(rsp_shortest_span),
      .rsp_longest_span(rsp_longest_span),
      .rsp_stored_count(rsp_stored_count),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   min_gap_checker #(
      .DEPTH(STORE_DEPTH)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_new_value(req_new_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_shortest_span(rsp_shortest_span),
      .rsp_longest_span(rsp_longest_span),
      .rsp_stored_count(rsp_stored_count),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .failures(failures),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Values: mostly random words sign-shifted by a random amount, so the
   // magnitudes (and with them the spread) cover every scale; now and then
   // an extreme or a repeat of something already sent.
   function automatic logic [WORD_W-1:0] pick_value();
      int                kind;
      logic [WORD_W-1:0] raw;
      kind = $urandom_range(0, 63);
      raw = $urandom;
      if (kind == 0) return MOST_NEGATIVE;
      if (kind == 1) return MOST_POSITIVE;
      if (kind <= 3 && sent_values.size() != 0)
         return sent_values[$urandom_range(0, sent_values.size() - 1)];
      return $signed(raw) >>> $urandom_range(0, 31);
   endfunction

   // Holds valid until the transfer; valid stays high on return so a
   // following item goes out back to back.
   task automatic offer_value(input logic [WORD_W-1:0] v);
      req_valid <= 1'b1;
      req_new_value <= v;
      sent_values = {sent_values, v};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Every item gives a result, so no results pending means the chain is empty.
   // One edge first, so the count already includes the last transfer.
   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items,
                            input bit gaps_allowed);
      set_capacity(cap);
      repeat (n_items) begin
         if (gaps_allowed && !quiet && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            req_new_value <= $urandom;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         offer_value(pick_value());
      end
   endtask

   // Result side: random stalls between ready stretches.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   initial begin : stimulus
      int fill_caps [6];
      int late_caps [5];

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_new_value <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Zero capacity: everything rejected with an empty store, spans zero.
      set_capacity(CAP_NONE);
      offer_value(MOST_NEGATIVE);
      offer_value(MOST_POSITIVE);
      offer_value('0);
      offer_value(MINUS_ONE);
      // One slot: a lone value (too few for spans), then a reject with one held.
      set_capacity(7'd1);
      offer_value('0);
      offer_value(MINUS_ONE);
      // Two slots: first valid spans, then a reject that still reports them.
      set_capacity(7'd2);
      offer_value(32'd7);
      offer_value(MOST_POSITIVE);

      // Filling in steps; the 5 lowers the limit under the count and the
      // repeated 30 starts with the store exactly at its limit.
      fill_caps = '{12, 5, 30, 30, 45, 60};
      foreach (fill_caps[p])
         run_phase(fill_caps[p][CAP_W-1:0], $urandom_range(140, 200),
                   $urandom_range(0, 2) != 0);

      // Last four slots: both extremes (spread hits its maximum) and repeats of
      // the stored 7 and 0 (shortest gap zero), then a reject at full depth.
      set_capacity(CAP_RESET);
      offer_value(MOST_NEGATIVE);
      offer_value(MOST_POSITIVE);
      offer_value(32'd7);
      offer_value('0);
      offer_value(MINUS_ONE);

      // Store full: limits above depth, zero and in between all reject.
      late_caps = '{127, 0, 100, 64, 127};
      foreach (late_caps[p]) begin
         if (p == 4) quiet = 1'b1;
         run_phase(late_caps[p][CAP_W-1:0], $urandom_range(140, 200),
                   $urandom_range(0, 2) != 0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3 * (STORE_DEPTH + 1)) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Hang guard: several times the slowest correct run.
   initial begin
      #30_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
